>>> design/trimmed_mean_overtemp_detector_defines.svh
// assertion macros used by the checker
`ifndef TRIMMED_MEAN_OVERTEMP_DETECTOR_DEFINES_SVH
`define TRIMMED_MEAN_OVERTEMP_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TMOD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmod check failed");

// next-cycle implication, sampled on clk, off during rst
`define TMOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmod check failed");

`endif

>>> design/tmod_pkg.sv
package tmod_pkg;

  localparam int WINDOW_SAMPLES = 10;
  localparam int AVERAGE_SHIFT  = 3;

  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 12;
  localparam int LIMIT_W     = 4;
  localparam int HOLD_W      = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam int ADDR_W = $clog2(WINDOW_SAMPLES);
  localparam int SUM_W  = $clog2(WINDOW_SAMPLES * (2 ** SAMPLE_W));

  localparam logic [ADDR_W-1:0]  WINDOW_LAST   = ADDR_W'(WINDOW_SAMPLES - 1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = '1;
  localparam logic [LEVEL_W-1:0] TRIP_RESET    = 12'd1907;
  localparam logic [LEVEL_W-1:0] RELEASE_RESET = 12'd2265;
  localparam logic [LIMIT_W-1:0] PERSIST_RESET = 4'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRIP    = 2'd0,
    REG_RELEASE = 2'd1,
    REG_PERSIST = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WALK   = 5'b00010,
    ST_TRIM   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } tmod_wr_t;

  typedef struct packed {
    logic                valid;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } tmod_stats_t;

endpackage

>>> design/tmod_store.sv
module tmod_store import tmod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tmod_wr_t    wr,
  input  logic        start,
  output tmod_stats_t stats
);

  logic [SAMPLE_W-1:0] mem [WINDOW_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                issuing;
  logic                pend;
  logic                pend_last;
  logic                done;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;

  // sample memory, one write or one read a cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issuing) begin
      rd_data <= mem[rd_addr];
    end
  end

  // walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      pend      <= 1'b0;
      pend_last <= 1'b0;
      done      <= 1'b0;
      rd_addr   <= '0;
    end else begin
      pend      <= issuing;
      pend_last <= issuing && (rd_addr == WINDOW_LAST);
      done      <= pend && pend_last;
      if (start) begin
        issuing <= 1'b1;
        rd_addr <= '0;
      end else if (issuing) begin
        rd_addr <= rd_addr + 1'b1;
        if (rd_addr == WINDOW_LAST) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  // running sum, minimum and maximum
  always_ff @(posedge clk) begin
    if (start) begin
      sum <= '0;
      lo  <= '1;
      hi  <= '0;
    end else if (pend) begin
      sum <= sum + SUM_W'(rd_data);
      if (rd_data < lo) begin
        lo <= rd_data;
      end
      if (rd_data > hi) begin
        hi <= rd_data;
      end
    end
  end

  assign stats = '{valid: done, sum: sum, lo: lo, hi: hi};

endmodule

>>> design/trimmed_mean_overtemp_detector.sv
// Trimmed-mean over-temperature detector. Each transfer on the sample channel stores one
// 12-bit ADC sample; every tenth sample closes a window, whose smallest and largest samples
// are dropped and whose remaining sum, shifted right by three, becomes the filtered level.
// The level drives a candidate flag through trip and release thresholds, and the alarm
// follows the candidate once the hold count exceeds persist_limit. Every sample gives one
// result. A sample that does not close a window goes from idle straight to the emit state;
// one that closes a window passes first through the walk, which reads the sample memory
// one entry per cycle, then through the trim and decide states. Samples are taken one
// at a time: in_stall is high from the transfer until the result is loaded into the output
// register. Register writes are taken every cycle.
module trimmed_mean_overtemp_detector import tmod_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_W-1:0]    sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   over_temperature,
  output logic                   window_done,
  output logic [LEVEL_W-1:0]     filtered_level,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t              state;
  state_t              state_next;
  logic [LEVEL_W-1:0]  trip_level;
  logic [LEVEL_W-1:0]  release_level;
  logic [LIMIT_W-1:0]  persist_limit;
  logic [ADDR_W-1:0]   fill_count;
  logic [HOLD_W-1:0]   hold_count;
  logic [HOLD_W-1:0]   hold_count_next;
  logic                candidate_flag;
  logic                candidate_flag_next;
  logic                alarm_flag;
  logic                alarm_flag_next;
  logic [LEVEL_W-1:0]  last_level;
  logic [LEVEL_W-1:0]  level_next;
  logic                res_done;
  logic                accept;
  logic                closes;
  logic                out_free;
  logic [SUM_W-1:0]    trimmed;
  logic [SUM_W-1:0]    shifted;
  logic                decided;
  tmod_wr_t            wr;
  tmod_stats_t         stats;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign closes    = (fill_count == WINDOW_LAST);
  assign out_free  = !out_valid || !out_stall;
  assign wr        = '{en: accept, addr: fill_count, data: sample};

  tmod_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .start (accept && closes),
    .stats (stats)
  );

  // trimmed level with saturation
  always_comb begin
    trimmed = stats.sum - SUM_W'(stats.lo) - SUM_W'(stats.hi);
    shifted = trimmed >> AVERAGE_SHIFT;
    if (shifted > SUM_W'(LEVEL_MAX)) begin
      level_next = LEVEL_MAX;
    end else begin
      level_next = shifted[LEVEL_W-1:0];
    end
  end

  // hysteresis and persistence
  always_comb begin
    candidate_flag_next = candidate_flag;
    alarm_flag_next     = alarm_flag;
    hold_count_next     = hold_count;
    decided             = 1'b1;
    if (last_level < trip_level) begin
      candidate_flag_next = 1'b1;
    end else if (last_level > release_level) begin
      candidate_flag_next = 1'b0;
    end else begin
      hold_count_next = '0;
      decided         = 1'b0;
    end
    if (decided) begin
      if (hold_count > HOLD_W'(persist_limit)) begin
        alarm_flag_next = candidate_flag_next;
        hold_count_next = '0;
      end else begin
        hold_count_next = hold_count + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = closes ? ST_WALK : ST_EMIT;
        end
      end
      ST_WALK: begin
        if (stats.valid) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      trip_level     <= TRIP_RESET;
      release_level  <= RELEASE_RESET;
      persist_limit  <= PERSIST_RESET;
      fill_count     <= '0;
      hold_count     <= '0;
      candidate_flag <= 1'b0;
      alarm_flag     <= 1'b0;
      last_level     <= '0;
      res_done       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRIP:    trip_level    <= cfg_data[LEVEL_W-1:0];
          REG_RELEASE: release_level <= cfg_data[LEVEL_W-1:0];
          REG_PERSIST: persist_limit <= cfg_data[LIMIT_W-1:0];
          default:     ;
        endcase
      end
      if (accept) begin
        res_done   <= closes;
        fill_count <= closes ? '0 : fill_count + 1'b1;
      end
      if (state == ST_TRIM) begin
        last_level <= level_next;
      end
      if (state == ST_DECIDE) begin
        candidate_flag <= candidate_flag_next;
        alarm_flag     <= alarm_flag_next;
        hold_count     <= hold_count_next;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      over_temperature <= alarm_flag;
      window_done      <= res_done;
      filtered_level   <= last_level;
    end
  end

endmodule

>>> design/tmod_checker.sv
`include "trimmed_mean_overtemp_detector_defines.svh"

module tmod_checker import tmod_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   over_temperature,
  input logic                   window_done,
  input logic [LEVEL_W-1:0]     filtered_level,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  // one sample in flight at a time
  `TMOD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `TMOD_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
    out_valid && $stable(filtered_level) && $stable(window_done) && $stable(over_temperature))

  // a new result is only loaded while the sample side is held off
  `TMOD_ASSERT_IMPLIES(a_result_after_work, $rose(out_valid), $past(in_stall))

  // register writes are never refused
  `TMOD_ASSERT_IMPLIES(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind trimmed_mean_overtemp_detector tmod_checker u_checker (.*);

>>> tb/sv/tmod_tb_pkg.sv
`timescale 1ns / 100ps
package tmod_tb_pkg;
  import tmod_pkg::*;

  // index that no register answers to
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               alarm;
    logic               done;
    logic [LEVEL_W-1:0] level;
  } overtemp_report_t;

  class overtemp_scoreboard;
    logic [SAMPLE_W-1:0] window_store [WINDOW_SAMPLES];
    int                  fill;
    logic [HOLD_W-1:0]   hold;
    logic                candidate;
    logic                alarm;
    logic [LEVEL_W-1:0]  level_now;
    logic [LEVEL_W-1:0]  trip;
    logic [LEVEL_W-1:0]  release_lvl;
    logic [LIMIT_W-1:0]  persist;
    overtemp_report_t    queued_reports [$];
    int                  mismatches;
    int                  reports_seen;
    int                  windows_seen;
    int                  alarm_reports;

    function new();
      fill = 0;
      hold = '0;
      candidate = 1'b0;
      alarm = 1'b0;
      level_now = '0;
      trip = TRIP_RESET;
      release_lvl = RELEASE_RESET;
      persist = PERSIST_RESET;
      mismatches = 0;
      reports_seen = 0;
      windows_seen = 0;
      alarm_reports = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TRIP:    trip = data[LEVEL_W-1:0];
        REG_RELEASE: release_lvl = data[LEVEL_W-1:0];
        REG_PERSIST: persist = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted sample, one report
    function void take_sample(logic [SAMPLE_W-1:0] s);
      int                sum;
      int                lo;
      int                hi;
      int                lvl;
      logic [HOLD_W-1:0] old;
      logic              decided;
      overtemp_report_t  rep;
      rep.done = 1'b0;
      if (fill >= WINDOW_SAMPLES) fill = 0;
      window_store[fill] = s;
      fill++;
      if (fill >= WINDOW_SAMPLES) begin
        sum = 0;
        lo = (1 << SAMPLE_W) - 1;
        hi = 0;
        foreach (window_store[i]) begin
          if (int'(window_store[i]) < lo) lo = int'(window_store[i]);
          if (int'(window_store[i]) > hi) hi = int'(window_store[i]);
          sum += int'(window_store[i]);
        end
        lvl = (sum - lo - hi) >> AVERAGE_SHIFT;
        if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
        fill = 0;
        rep.done = 1'b1;
        level_now = lvl[LEVEL_W-1:0];
        decided = 1'b1;
        if (level_now < trip) begin
          candidate = 1'b1;
        end else if (level_now > release_lvl) begin
          candidate = 1'b0;
        end else begin
          hold = '0;
          decided = 1'b0;
        end
        if (decided) begin
          old = hold;
          hold = HOLD_W'(old + 1'b1);
          if (old > persist) begin
            alarm = candidate;
            hold = '0;
          end
        end
      end
      rep.alarm = alarm;
      rep.level = level_now;
      queued_reports.push_back(rep);
    endfunction

    function void check_result(logic ot, logic wd, logic [LEVEL_W-1:0] lvl);
      overtemp_report_t want;
      if (queued_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: alarm %0b done %0b level %0d",
                   $time, ot, wd, lvl);
        return;
      end
      want = queued_reports.pop_front();
      reports_seen++;
      if (wd === 1'b1) windows_seen++;
      if (ot === 1'b1) alarm_reports++;
      if (ot !== want.alarm || wd !== want.done || lvl !== want.level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected alarm %0b done %0b level %0d, got %0b %0b %0d",
                   $time, want.alarm, want.done, want.level, ot, wd, lvl);
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import tmod_pkg::*;
  import tmod_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;

  localparam int MODE_LOW     = 0;
  localparam int MODE_HIGH    = 1;
  localparam int MODE_BETWEEN = 2;
  localparam int MODE_NOISE   = 3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   over_temperature;
  logic                   window_done;
  logic [LEVEL_W-1:0]     filtered_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                   idling = 1'b1;
  int                     out_hold = 0;
  int                     cycles = 0;
  int                     samples_sent = 0;
  overtemp_scoreboard     sb;

  trimmed_mean_overtemp_detector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .over_temperature(over_temperature),
    .window_done(window_done),
    .filtered_level(filtered_level),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.queued_reports.size());
      $display("** trimmed_mean_overtemp_detector: FAILED **");
      $finish;
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_hold <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(over_temperature, window_done, filtered_level);
  end

  // called at a falling edge, returns at a falling edge with valid left high
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_thresholds(int trip, int rel, int persist);
    write_reg(REG_TRIP, CFG_DATA_W'(trip));
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_RELEASE, CFG_DATA_W'(rel));
    write_reg(REG_PERSIST, CFG_DATA_W'(persist));
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] s);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_sample(s);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.queued_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // windows mostly cluster around a level below trip, above release or between the two
  task automatic run_phase(int count);
    int mode;
    int centre;
    int v;
    int t;
    int r;
    mode = MODE_NOISE;
    centre = 0;
    for (int i = 0; i < count; i++) begin
      if (sb.fill == 0 && (i == 0 || $urandom_range(0, 5) == 0)) begin
        mode = $urandom_range(MODE_LOW, MODE_NOISE);
        t = int'(sb.trip);
        r = int'(sb.release_lvl);
        centre = int'($urandom_range(0, 4095));
        case (mode)
          MODE_LOW:     if (t > 0) centre = int'($urandom_range(0, t - 1));
          MODE_HIGH:    if (r < 4095) centre = int'($urandom_range(r + 1, 4095));
          MODE_BETWEEN: if (t <= r) centre = int'($urandom_range(t, r));
          default: ;
        endcase
      end
      if (mode == MODE_NOISE || $urandom_range(0, 9) == 0) begin
        v = int'($urandom_range(0, 4095));
      end else begin
        v = centre + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      push_sample(SAMPLE_W'(v));
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_window [WINDOW_SAMPLES];
    int                  t;
    int                  r;
    int                  tmp;
    sb = new();
    corner_window = '{12'd0, 12'hfff, 12'haaa, 12'h555, 12'hfff,
                      12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;

    // extremes of the sample, then an all-zero window
    foreach (corner_window[i]) push_sample(corner_window[i]);
    for (int i = 0; i < WINDOW_SAMPLES; i++) push_sample('0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: set_thresholds(1907, 2265, 4);
        1: set_thresholds(4095, 0, 0);       // trip above release
        2: set_thresholds(0, 4095, 15);
        3: set_thresholds(2048, 2048, 15);
        4: set_thresholds(2048, 2048, 0);    // persistence lowered with a count held
        default: begin
          t = $urandom_range(0, 4095);
          r = $urandom_range(0, 4095);
          if ($urandom_range(0, 1) == 0 && t > r) begin
            tmp = t;
            t = r;
            r = tmp;
          end
          set_thresholds(t, r, $urandom_range(0, 15));
        end
      endcase
      if (p == PHASES - 1) idling <= 1'b0;
      run_phase(110 + $urandom_range(0, 15));
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d samples and %0d results over %0d threshold settings",
             samples_sent, sb.reports_seen, PHASES + 1);
    $display("%0d windows closed, %0d results with the alarm raised, %0d mismatches",
             sb.windows_seen, sb.alarm_reports, sb.mismatches);
    if (sb.mismatches == 0 && sb.queued_reports.size() == 0) begin
      $display("** trimmed_mean_overtemp_detector: PASSED **");
    end else begin
      $display("** trimmed_mean_overtemp_detector: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/tmod_pkg.sv
design/tmod_store.sv
design/trimmed_mean_overtemp_detector.sv
design/tmod_checker.sv
tb/sv/tmod_tb_pkg.sv
tb/sv/tb_top.sv
